FILE: sv/cbm_pkg.sv
// ----------------------------------------------------------------------------
// cbm_pkg
// Types and constants shared by the cartridge bank mapper modules.
// ----------------------------------------------------------------------------
package cbm_pkg;

  localparam logic [1:0] KIND_CPU_WRITE = 2'd0;
  localparam logic [1:0] KIND_CPU_READ  = 2'd1;
  localparam logic [1:0] KIND_PPU_ADDR  = 2'd2;
  localparam logic [1:0] KIND_CHR_READ  = 2'd3;

  localparam logic [7:0] PAGE_PRG_LOW  = 8'h50;
  localparam logic [7:0] PAGE_PROTECT  = 8'h51;
  localparam logic [7:0] PAGE_PRG_HIGH = 8'h52;
  localparam logic [7:0] PAGE_MODE     = 8'h53;

  localparam logic [3:0] READ_WINDOW    = 4'h5;
  localparam logic [7:0] PROTECT_TOGGLE = 8'h04;
  localparam logic [5:0] BANK_FILL      = 6'h03;

  localparam logic CFG_SWAP_DISABLED = 1'b0;
  localparam logic CFG_LARGE_PRG_ROM = 1'b1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] address;
    logic [7:0]  write_value;
    logic [7:0]  open_bus;
  } cbm_in_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        read_claimed;
    logic [5:0]  prg_bank;
    logic [13:0] chr_address;
  } cbm_out_t;

  typedef struct packed {
    logic swap_disabled;
    logic large_prg_rom;
  } cbm_cfg_t;

  typedef struct packed {
    logic [7:0] prg_low_reg;
    logic [7:0] protect_reg;
    logic [7:0] prg_high_reg;
    logic [7:0] mode_reg;
    logic       latched_a9;
    logic       last_a13;
  } cbm_state_t;

  function automatic logic [7:0] swap_low_bits(input logic [7:0] v);
    return {v[7:2], v[0], v[1]};
  endfunction

endpackage

FILE: sv/cbm_step.sv
// ----------------------------------------------------------------------------
// cbm_step
// Decodes one bus beat against the mapper state: next state and result.
// ----------------------------------------------------------------------------
module cbm_step (
  input  cbm_pkg::cbm_cfg_t   cfg,
  input  cbm_pkg::cbm_state_t state,
  input  cbm_pkg::cbm_in_t    item,
  output cbm_pkg::cbm_state_t state_next,
  output cbm_pkg::cbm_out_t   result
);
  import cbm_pkg::*;

  logic       swap;
  logic [7:0] swapped;
  logic [7:0] prot_value;

  assign swap       = state.mode_reg[0];
  assign swapped    = swap_low_bits(item.write_value);
  assign prot_value = swap ? swapped : item.write_value;

  always_comb begin
    state_next         = state;
    result.read_data   = 8'h00;
    result.read_claimed = 1'b0;
    result.chr_address = 14'h0000;
    unique case (item.kind)
      KIND_CPU_WRITE: begin
        unique case (item.address[15:8])
          PAGE_PRG_LOW: begin
            state_next.prg_low_reg = prot_value;
          end
          PAGE_PROTECT: begin
            if (item.address[0]) begin
              if (state.protect_reg[0] && !prot_value[0]) begin
                state_next.protect_reg = state.protect_reg ^ PROTECT_TOGGLE;
              end
            end else begin
              state_next.protect_reg = prot_value;
            end
          end
          PAGE_PRG_HIGH: begin
            state_next.prg_high_reg = (swap && cfg.large_prg_rom) ? swapped : item.write_value;
          end
          PAGE_MODE: begin
            state_next.mode_reg = cfg.swap_disabled ? {item.write_value[7:1], 1'b0}
                                                    : item.write_value;
          end
          default: begin
          end
        endcase
      end
      KIND_CPU_READ: begin
        if (item.address[15:12] == READ_WINDOW) begin
          result.read_claimed = 1'b1;
          result.read_data    = item.address[11] ? item.open_bus
                                                 : (~state.protect_reg & PROTECT_TOGGLE);
        end
      end
      KIND_PPU_ADDR: begin
        if (!state.last_a13 && item.address[13]) begin
          state_next.latched_a9 = item.address[9];
        end
        state_next.last_a13 = item.address[13];
      end
      KIND_CHR_READ: begin
        if (state.prg_low_reg[7] && !state.last_a13) begin
          result.chr_address = {1'b0, state.latched_a9, item.address[11:0]};
        end else begin
          result.chr_address = item.address[13:0];
        end
      end
      default: begin
      end
    endcase
    // bank reflects the state after this beat
    result.prg_bank = {state_next.prg_high_reg[1:0], state_next.prg_low_reg[3:0]}
                      | (state_next.mode_reg[2] ? 6'h00 : BANK_FILL);
  end

endmodule

FILE: sv/cartridge_bank_mapper_with_chr_latch_core.sv
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_with_chr_latch_core
// Bank mapper with CHR latch: input register, decode, result register.
// ----------------------------------------------------------------------------
// an accepted input beat passes the input register and then the result register
// throughput: one beat per cycle, limited only by the output stall
// the mapper state is updated as a beat moves from the input to the result register
// reset (synchronous) clears both pipeline stages, mapper registers and config
module cartridge_bank_mapper_with_chr_latch_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  cbm_pkg::cbm_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output cbm_pkg::cbm_out_t out_data,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic              cfg_data
);
  import cbm_pkg::*;

  cbm_cfg_t   cfg;
  cbm_state_t state;
  cbm_state_t state_next;
  cbm_in_t    item;
  logic       item_valid;
  cbm_out_t   result;
  logic       out_ready;
  logic       advance;

  assign out_ready = !out_valid || !out_stall;
  assign advance   = item_valid && out_ready;
  assign in_stall  = item_valid && !out_ready;

  cbm_step u_step (
    .cfg        (cfg),
    .state      (state),
    .item       (item),
    .state_next (state_next),
    .result     (result)
  );

  // config port
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SWAP_DISABLED: cfg.swap_disabled <= cfg_data;
        CFG_LARGE_PRG_ROM: cfg.large_prg_rom <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item <= in_data;
    end
  end

  // mapper state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        state <= state_next;
      end
      if (out_ready) begin
        out_valid <= item_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the cartridge bank mapper core, one result beat per bus item.
// Bus items go in through a valid/stall channel with random gaps. A mirror of
// the mapper registers, the A9 latch and the A13 edge detector predicts every
// result beat. The results are compared field by field as they leave, while
// the output side stalls at random and once holds off for a long stretch.
// Runs cover directed corner items and then random traffic under every
// setting of the two config bits.
// ----------------------------------------------------------------------------
module testbench;
  import cbm_pkg::*;

  localparam int HALF_PERIOD = 4;
  localparam int IDLE_LIMIT  = 500;
  localparam int HOLD_CYCLES = 60;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_stall;
  cbm_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  cbm_out_t out_data;
  logic     cfg_we = 1'b0;
  logic     cfg_index = 1'b0;
  logic     cfg_data = 1'b0;

  cartridge_bank_mapper_with_chr_latch_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // mapper mirror
  logic [7:0] prg_low_q;
  logic [7:0] protect_q;
  logic [7:0] prg_high_q;
  logic [7:0] mode_q;
  logic       a9_q;
  logic       a13_q;
  logic       swap_off_q;
  logic       big_rom_q;

  cbm_out_t bus_results_due[$];
  cbm_out_t due_now;
  cbm_out_t mapped;

  int errors       = 0;
  int beats_in     = 0;
  int beats_out    = 0;
  int idle_cycles  = 0;
  int rx_gap       = 0;
  int hold_left    = 0;
  bit idle_on      = 1'b1;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at result beat %0d: %s got 0x%0h expected 0x%0h",
             beats_out, what, got, want);
    errors++;
  endtask

  task automatic map_bus_item(input cbm_in_t it, output cbm_out_t res);
    logic [7:0] d;
    logic       sw;
    res = '0;
    case (it.kind)
      KIND_CPU_WRITE: begin
        sw = mode_q[0];
        d  = it.write_value;
        case (it.address[15:8])
          PAGE_PRG_LOW:  prg_low_q = sw ? {d[7:2], d[0], d[1]} : d;
          PAGE_PROTECT: begin
            if (sw) d = {d[7:2], d[0], d[1]};
            if (it.address[0]) begin
              if (protect_q[0] && !d[0]) protect_q = protect_q ^ PROTECT_TOGGLE;
            end else begin
              protect_q = d;
            end
          end
          PAGE_PRG_HIGH: prg_high_q = (sw && big_rom_q) ? {d[7:2], d[0], d[1]} : d;
          PAGE_MODE:     mode_q = swap_off_q ? {d[7:1], 1'b0} : d;
          default: ;
        endcase
      end
      KIND_CPU_READ: begin
        if (it.address[15:12] == READ_WINDOW) begin
          res.read_claimed = 1'b1;
          res.read_data = it.address[11] ? it.open_bus : (~protect_q & PROTECT_TOGGLE);
        end
      end
      KIND_PPU_ADDR: begin
        if (!a13_q && it.address[13]) a9_q = it.address[9];
        a13_q = it.address[13];
      end
      default: begin
        if (prg_low_q[7] && !a13_q) res.chr_address = {1'b0, a9_q, it.address[11:0]};
        else res.chr_address = it.address[13:0];
      end
    endcase
    res.prg_bank = {prg_high_q[1:0], prg_low_q[3:0]} | (mode_q[2] ? 6'd0 : BANK_FILL);
  endtask

  // predictor: config writes and accepted input beats
  always @(posedge clk) begin
    if (rst) begin
      prg_low_q  = '0;
      protect_q  = '0;
      prg_high_q = '0;
      mode_q     = '0;
      a9_q       = 1'b0;
      a13_q      = 1'b0;
      swap_off_q = 1'b0;
      big_rom_q  = 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SWAP_DISABLED: swap_off_q = cfg_data;
          CFG_LARGE_PRG_ROM: big_rom_q  = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        map_bus_item(in_data, mapped);
        bus_results_due.push_back(mapped);
        beats_in++;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (bus_results_due.size() == 0) begin
        report_mismatch("result beat with nothing due", 32'(out_data), 0);
      end else begin
        due_now = bus_results_due.pop_front();
        if (out_data.read_data !== due_now.read_data)
          report_mismatch("read_data", 32'(out_data.read_data), 32'(due_now.read_data));
        if (out_data.read_claimed !== due_now.read_claimed)
          report_mismatch("read_claimed", 32'(out_data.read_claimed),
                          32'(due_now.read_claimed));
        if (out_data.prg_bank !== due_now.prg_bank)
          report_mismatch("prg_bank", 32'(out_data.prg_bank), 32'(due_now.prg_bank));
        if (out_data.chr_address !== due_now.chr_address)
          report_mismatch("chr_address", 32'(out_data.chr_address),
                          32'(due_now.chr_address));
      end
      beats_out++;
      rx_gap = idle_on ? $urandom_range(0, 5) : 0;
    end
  end

  // receiver stall
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (rx_gap > 0) begin
      out_stall <= 1'b1;
      rx_gap--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no beat moved for %0d cycles", IDLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  function automatic cbm_in_t bus_item(input logic [1:0] kind, input logic [15:0] addr,
                                       input logic [7:0] wv, input logic [7:0] ob);
    cbm_in_t it;
    it.kind        = kind;
    it.address     = addr;
    it.write_value = wv;
    it.open_bus    = ob;
    return it;
  endfunction

  function automatic cbm_in_t random_item();
    cbm_in_t it;
    int      pick;
    it.kind        = 2'($urandom_range(0, 3));
    it.address     = 16'($urandom);
    it.write_value = 8'($urandom);
    it.open_bus    = 8'($urandom);
    pick = $urandom_range(0, 9);
    case (it.kind)
      KIND_CPU_WRITE: if (pick < 8) it.address[15:8] = PAGE_PRG_LOW + 8'($urandom_range(0, 3));
      KIND_CPU_READ:  if (pick < 8) it.address[15:12] = READ_WINDOW;
      default: ;
    endcase
    return it;
  endfunction

  task automatic send_item(input cbm_in_t it);
    int gap;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_quiet();
    @(negedge clk);
    in_valid <= 1'b0;
    while (bus_results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic test_register_corners();
    send_item(bus_item(KIND_CPU_READ,  16'h5000, 8'h00, 8'h00));
    send_item(bus_item(KIND_CPU_READ,  16'h5FFF, 8'hFF, 8'hFF));
    send_item(bus_item(KIND_CPU_READ,  16'h4FFF, 8'h00, 8'hFF));
    send_item(bus_item(KIND_CPU_READ,  16'hFFFF, 8'hFF, 8'hFF));
    send_item(bus_item(KIND_CPU_WRITE, 16'h5300, 8'h05, 8'h00));
    send_item(bus_item(KIND_CPU_WRITE, 16'h5000, 8'h81, 8'h00));
    send_item(bus_item(KIND_CPU_WRITE, 16'h5200, 8'h01, 8'h00));
    send_item(bus_item(KIND_CPU_WRITE, 16'h5100, 8'h02, 8'h00));
    send_item(bus_item(KIND_CPU_WRITE, 16'h5101, 8'h02, 8'h00));
    send_item(bus_item(KIND_CPU_WRITE, 16'h51FF, 8'h01, 8'h00));
    send_item(bus_item(KIND_CPU_READ,  16'h57FF, 8'h00, 8'hAA));
    send_item(bus_item(KIND_CPU_WRITE, 16'h5400, 8'hFF, 8'hFF));
    send_item(bus_item(KIND_CPU_WRITE, 16'hFFFF, 8'hFF, 8'hFF));
    send_item(bus_item(KIND_CPU_WRITE, 16'h0000, 8'h00, 8'h00));
  endtask

  task automatic test_chr_latch();
    send_item(bus_item(KIND_PPU_ADDR,  16'h2200, 8'h00, 8'h00));
    send_item(bus_item(KIND_CHR_READ,  16'h0ABC, 8'h00, 8'h00));
    send_item(bus_item(KIND_PPU_ADDR,  16'h0000, 8'h00, 8'h00));
    send_item(bus_item(KIND_CHR_READ,  16'hFFFF, 8'hFF, 8'hFF));
    send_item(bus_item(KIND_PPU_ADDR,  16'h3DFF, 8'h00, 8'h00));
    send_item(bus_item(KIND_PPU_ADDR,  16'hDFFF, 8'h00, 8'h00));
    send_item(bus_item(KIND_PPU_ADDR,  16'h1000, 8'h00, 8'h00));
    send_item(bus_item(KIND_CHR_READ,  16'h3FFF, 8'h00, 8'h00));
    send_item(bus_item(KIND_CPU_WRITE, 16'h5300, 8'h00, 8'h00));
    send_item(bus_item(KIND_CHR_READ,  16'hC123, 8'h00, 8'h00));
  endtask

  task automatic test_config_swaps();
    wait_quiet();
    write_cfg(CFG_SWAP_DISABLED, 1'b1);
    write_cfg(CFG_LARGE_PRG_ROM, 1'b1);
    send_item(bus_item(KIND_CPU_WRITE, 16'h5300, 8'h05, 8'h00));
    send_item(bus_item(KIND_CPU_WRITE, 16'h5200, 8'h02, 8'h00));
    wait_quiet();
    write_cfg(CFG_SWAP_DISABLED, 1'b0);
    send_item(bus_item(KIND_CPU_WRITE, 16'h5300, 8'h01, 8'h00));
    send_item(bus_item(KIND_CPU_WRITE, 16'h5200, 8'h02, 8'h00));
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 8; phase++) begin
      wait_quiet();
      write_cfg(CFG_SWAP_DISABLED, phase[0]);
      write_cfg(CFG_LARGE_PRG_ROM, phase[1]);
      idle_on = (phase % 4) != 3;
      repeat (165) send_item(random_item());
    end
    idle_on = 1'b1;
  endtask

  task automatic test_output_hold();
    wait_quiet();
    idle_on   = 1'b0;
    hold_left = HOLD_CYCLES;
    repeat (24) send_item(random_item());
    idle_on   = 1'b1;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_register_corners();
    test_chr_latch();
    test_config_swaps();
    test_output_hold();
    test_random_traffic();
    wait_quiet();
    $display("covered %0d bus items and %0d result beats over all four config settings,",
             beats_in, beats_out);
    $display("with random gaps on both sides and a %0d-cycle output hold", HOLD_CYCLES);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
